// ===== design/slid_pkg.sv =====
package slid_pkg;

  // Request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  localparam int ENTRY_COUNT_W = 5;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] operand_value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0]       entry_value;
    logic [1:0]               status;
    logic [ENTRY_COUNT_W-1:0] entry_count;
    logic                     last;
  } out_word_t;

endpackage

// ===== design/slid_mem.sv =====
module slid_mem
  import slid_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic signed [31:0] wdata,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  output logic signed [31:0] rdata
);

  logic signed [31:0] mem_r [DEPTH];
  logic signed [31:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port; data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/slid_oreg.sv =====
module slid_oreg
  import slid_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_word_t load_data,
  output logic      slot_free,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  logic      valid_r;
  logic      valid_nxt;
  out_word_t data_r;

  // Slot is free when empty or being taken this cycle
  assign slot_free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the word while stalled
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== design/slid_ctrl.sv =====
module slid_ctrl
  import slid_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int CW       = 5,
  parameter int AW       = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_word_t           in_data,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output logic signed [31:0] mem_wdata,
  output logic               mem_re,
  output logic [AW-1:0]      mem_raddr,
  input  logic signed [31:0] mem_rdata,
  input  logic               slot_free,
  output logic               load,
  output out_word_t          load_data
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_INS_RD   = 8'b0000_0010,
    S_INS_WR   = 8'b0000_0100,
    S_DEL_RD   = 8'b0000_1000,
    S_DEL_CHK  = 8'b0001_0000,
    S_OUT_RD   = 8'b0010_0000,
    S_OUT_EMIT = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      ptr_r, ptr_nxt;
  logic               found_r, found_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic [1:0]         res_status_r, res_status_nxt;
  logic signed [31:0] res_value_r, res_value_nxt;
  logic [CW-1:0]      ptr_dec;
  logic [CW-1:0]      ptr_inc;
  logic               accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign ptr_dec  = ptr_r - CW'(1);
  assign ptr_inc  = ptr_r + CW'(1);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    found_nxt      = found_r;
    val_nxt        = val_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = '0;
    load           = 1'b0;
    load_data      = '0;

    case (state_r)
      // Take a request and dispatch it
      S_IDLE: begin
        if (accept) begin
          val_nxt       = in_data.operand_value;
          res_value_nxt = in_data.operand_value;
          case (in_data.req_type)
            REQ_INSERT: begin
              if (count_r >= CW'(CAPACITY)) begin
                res_status_nxt = ST_FULL;
                state_nxt      = S_DONE;
              end else begin
                ptr_nxt   = count_r;
                state_nxt = S_INS_RD;
              end
            end
            REQ_DELETE: begin
              ptr_nxt   = '0;
              found_nxt = 1'b0;
              state_nxt = S_DEL_RD;
            end
            REQ_READ: begin
              if (count_r == '0) begin
                res_value_nxt  = '0;
                res_status_nxt = ST_EMPTY;
                state_nxt      = S_DONE;
              end else begin
                ptr_nxt   = '0;
                state_nxt = S_OUT_RD;
              end
            end
            default: begin
              count_nxt      = '0;
              res_status_nxt = ST_OK;
              state_nxt      = S_DONE;
            end
          endcase
        end
      end

      // Insert: walk down from the top, fetching the entry below the hole
      S_INS_RD: begin
        if (ptr_r == '0) begin
          mem_we         = 1'b1;
          mem_waddr      = ptr_r[AW-1:0];
          mem_wdata      = val_r;
          count_nxt      = count_r + CW'(1);
          res_status_nxt = ST_OK;
          state_nxt      = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_dec[AW-1:0];
          state_nxt = S_INS_WR;
        end
      end

      // Insert: shift a larger or equal entry up, or drop the operand into the hole
      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r[AW-1:0];
        if (mem_rdata >= val_r) begin
          mem_wdata = mem_rdata;
          ptr_nxt   = ptr_dec;
          state_nxt = S_INS_RD;
        end else begin
          mem_wdata      = val_r;
          count_nxt      = count_r + CW'(1);
          res_status_nxt = ST_OK;
          state_nxt      = S_DONE;
        end
      end

      // Delete: fetch the next entry or finish the scan
      S_DEL_RD: begin
        if (ptr_r == count_r) begin
          if (found_r) begin
            count_nxt      = count_r - CW'(1);
            res_status_nxt = ST_OK;
          end else begin
            res_status_nxt = ST_NOT_FOUND;
          end
          state_nxt = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_r[AW-1:0];
          state_nxt = S_DEL_CHK;
        end
      end

      // Delete: match the operand, then pull later entries down by one
      S_DEL_CHK: begin
        if (found_r) begin
          mem_we    = 1'b1;
          mem_waddr = ptr_dec[AW-1:0];
          mem_wdata = mem_rdata;
        end else if (mem_rdata == val_r) begin
          found_nxt = 1'b1;
        end
        ptr_nxt   = ptr_inc;
        state_nxt = S_DEL_RD;
      end

      // Read out: fetch one entry
      S_OUT_RD: begin
        mem_re    = 1'b1;
        mem_raddr = ptr_r[AW-1:0];
        state_nxt = S_OUT_EMIT;
      end

      // Read out: hand the entry on once the output slot frees
      S_OUT_EMIT: begin
        if (slot_free) begin
          load                  = 1'b1;
          load_data.entry_value = mem_rdata;
          load_data.status      = ST_OK;
          load_data.entry_count = ENTRY_COUNT_W'(count_r);
          load_data.last        = (ptr_inc == count_r);
          if (ptr_inc == count_r) begin
            state_nxt = S_IDLE;
          end else begin
            ptr_nxt   = ptr_inc;
            state_nxt = S_OUT_RD;
          end
        end
      end

      // Single-word result
      S_DONE: begin
        if (slot_free) begin
          load                  = 1'b1;
          load_data.entry_value = res_value_r;
          load_data.status      = res_status_r;
          load_data.entry_count = ENTRY_COUNT_W'(count_r);
          load_data.last        = 1'b1;
          state_nxt             = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ptr_r   <= '0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ptr_r   <= ptr_nxt;
      found_r <= found_nxt;
    end
  end

  // Operand and pending result
  always_ff @(posedge clk) begin
    val_r        <= val_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
  end

endmodule

// ===== design/sorted_list_insert_delete.sv =====
// Sorted value store: up to CAPACITY signed 32-bit values kept in ascending
// order in a single-port-read, single-port-write memory.
// Input channel (in_valid/in_stall/in_data) carries one request word:
// insert, delete by value, read out all, or clear. in_stall is high while a
// request is being worked; a new word is taken as soon as the previous one
// has been fully issued, even if its last result is still waiting.
// Result channel (out_valid/out_stall/out_data) is fed from one output
// register. Insert, delete and clear give one word; read out gives one word
// per stored value (last set on the final one), or one empty word.
// Each step waits on the registered memory read: insert moves each larger or
// equal entry up in turn, delete scans every stored entry, and read out
// fetches and emits the stored entries in order.
// A stalled receiver holds the output word and pauses read out.
// Reset (rst_n low, synchronous) empties the store and the output register;
// memory contents are left as they are and no clearing pass is needed.
module sorted_list_insert_delete
  import slid_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic signed [31:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic signed [31:0] mem_rdata;
  logic               slot_free;
  logic               load;
  out_word_t          load_data;

  slid_mem #(
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  slid_ctrl #(
    .CAPACITY(CAPACITY),
    .CW      (CW),
    .AW      (AW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata),
    .slot_free(slot_free),
    .load     (load),
    .load_data(load_data)
  );

  slid_oreg u_oreg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load),
    .load_data(load_data),
    .slot_free(slot_free),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

// ===== design/slid_chk.sv =====
module slid_chk
  import slid_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  // Reset leaves no word on the output
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid straight after reset");

  // Stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");

  // Refused insert only when the store is full
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FULL |->
      out_data.entry_count == ENTRY_COUNT_W'(CAPACITY) && out_data.last)
    else $error("full status with wrong count");

  // Empty read out is a single zero word
  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_EMPTY |->
      out_data.entry_count == '0 && out_data.last && out_data.entry_value == '0)
    else $error("malformed empty word");

  // Not-found result ends its request
  a_not_found_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_NOT_FOUND |-> out_data.last)
    else $error("not-found word without last");

endmodule

bind sorted_list_insert_delete slid_chk #(.CAPACITY(CAPACITY)) u_slid_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import slid_pkg::*;

  localparam int CAPACITY = 16;
  localparam int DRAIN_CYCLES = 40;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  // Mirror of the store, updated as each request word is accepted
  logic signed [31:0] mirror_entries [CAPACITY];
  int                 mirror_count = 0;
  out_word_t          pending_words [$];
  out_word_t          oldest_word;
  int                 err_count = 0;

  int          burst_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;
  int          stall_phase = 0;

  sorted_list_insert_delete #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Queue one result word, counting the store after the request
  function automatic void push_result(input logic signed [31:0] value,
                                      input logic [1:0] status, input logic last_word);
    out_word_t w;
    w.entry_value = value;
    w.status      = status;
    w.entry_count = mirror_count[ENTRY_COUNT_W-1:0];
    w.last        = last_word;
    pending_words.push_back(w);
  endfunction

  // Apply one accepted request to the mirror and queue its results
  function automatic void predict_request(input in_word_t req_word);
    int pos;
    int idx;
    logic signed [31:0] val;
    val = req_word.operand_value;
    case (req_word.req_type)
      REQ_INSERT: begin
        if (mirror_count >= CAPACITY) begin
          push_result(val, ST_FULL, 1'b1);
        end else begin
          pos = mirror_count;
          for (idx = 0; idx < mirror_count; idx++) begin
            if (mirror_entries[idx] >= val) begin
              pos = idx;
              break;
            end
          end
          for (idx = mirror_count; idx > pos; idx--)
            mirror_entries[idx] = mirror_entries[idx-1];
          mirror_entries[pos] = val;
          mirror_count++;
          push_result(val, ST_OK, 1'b1);
        end
      end
      REQ_DELETE: begin
        pos = -1;
        for (idx = 0; idx < mirror_count; idx++) begin
          if (mirror_entries[idx] == val) begin
            pos = idx;
            break;
          end
        end
        if (pos < 0) begin
          push_result(val, ST_NOT_FOUND, 1'b1);
        end else begin
          for (idx = pos; idx + 1 < mirror_count; idx++)
            mirror_entries[idx] = mirror_entries[idx+1];
          mirror_count--;
          push_result(val, ST_OK, 1'b1);
        end
      end
      REQ_READ: begin
        if (mirror_count == 0) begin
          push_result('0, ST_EMPTY, 1'b1);
        end else begin
          for (idx = 0; idx < mirror_count; idx++)
            push_result(mirror_entries[idx], ST_OK, idx == mirror_count - 1);
        end
      end
      default: begin
        mirror_count = 0;
        push_result(val, ST_OK, 1'b1);
      end
    endcase
  endfunction

  // Send one request word in bursts with random gaps, then predict it
  task automatic send_request(input logic [1:0] req, input logic signed [31:0] operand);
    in_word_t w;
    int gap;
    w.req_type      = req;
    w.operand_value = operand;
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    predict_request(w);
  endtask

  // Mix of small values, stored values and edge values
  function automatic logic signed [31:0] pick_operand();
    logic signed [31:0] v;
    int r;
    r = $urandom_range(99);
    if (r < 40) begin
      v = int'($urandom_range(16)) - 8;
    end else if (r < 60 && mirror_count > 0) begin
      v = mirror_entries[$urandom_range(mirror_count - 1)];
    end else if (r < 85) begin
      v = $urandom;
    end else begin
      case ($urandom_range(5))
        0: v = VAL_MIN;
        1: v = VAL_MAX;
        2: v = VAL_MIN + 1;
        3: v = VAL_MAX - 1;
        4: v = -1;
        default: v = 0;
      endcase
    end
    return v;
  endfunction

  task automatic test_empty_store();
    send_request(REQ_READ, VAL_MAX);
    send_request(REQ_DELETE, VAL_MIN);
    send_request(REQ_CLEAR, VAL_MAX);
  endtask

  task automatic test_value_extremes();
    send_request(REQ_INSERT, VAL_MAX);
    send_request(REQ_INSERT, VAL_MIN);
    send_request(REQ_INSERT, 0);
    send_request(REQ_INSERT, -1);
    // duplicates land in front of their equals
    send_request(REQ_INSERT, 0);
    send_request(REQ_INSERT, VAL_MIN);
    send_request(REQ_READ, 32'sh5a5a_5a5a);
    send_request(REQ_DELETE, 0);
    send_request(REQ_DELETE, 7);
  endtask

  task automatic test_fill_and_overflow();
    while (mirror_count < CAPACITY)
      send_request(REQ_INSERT, $urandom);
    // refused while full
    send_request(REQ_INSERT, VAL_MAX);
    send_request(REQ_READ, 0);
    send_request(REQ_CLEAR, VAL_MIN);
  endtask

  task automatic test_random_traffic(input int n_items);
    int sent;
    int phase_left;
    int insert_pct;
    int r;
    logic [1:0] req;
    logic signed [31:0] operand;
    sent = 0;
    phase_left = 0;
    insert_pct = 50;
    while (sent < n_items) begin
      // change fill pressure every few dozen words
      if (phase_left == 0) begin
        phase_left = $urandom_range(40, 15);
        case ($urandom_range(2))
          0: insert_pct = 80;
          1: insert_pct = 50;
          default: insert_pct = 25;
        endcase
      end
      r = $urandom_range(99);
      if (r < 6) req = REQ_READ;
      else if (r < 8) req = REQ_CLEAR;
      else if ($urandom_range(99) < insert_pct) req = REQ_INSERT;
      else req = REQ_DELETE;
      if (req == REQ_DELETE && mirror_count > 0 && $urandom_range(9) < 6)
        operand = mirror_entries[$urandom_range(mirror_count - 1)];
      else
        operand = pick_operand();
      send_request(req, operand);
      sent++;
      phase_left--;
    end
  endtask

  // Stall the result channel in phases of differing pressure
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(3));
      stall_left = $urandom_range(200, 20);
    end
    stall_left--;
    stall_phase++;
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(3) == 0);
      STALL_PERIODIC: out_stall <= ((stall_phase % 5) >= 3);
      default:        out_stall <= ($urandom_range(9) < 7);
    endcase
  end

  task automatic report_mismatch(input string field, input longint want, input longint got);
    err_count++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result word, expected none, actual %h", $time, out_data);
      end else begin
        oldest_word = pending_words.pop_front();
        if (out_data.entry_value !== oldest_word.entry_value)
          report_mismatch("entry_value", oldest_word.entry_value, out_data.entry_value);
        if (out_data.status !== oldest_word.status)
          report_mismatch("status", oldest_word.status, out_data.status);
        if (out_data.entry_count !== oldest_word.entry_count)
          report_mismatch("entry_count", oldest_word.entry_count, out_data.entry_count);
        if (out_data.last !== oldest_word.last)
          report_mismatch("last", oldest_word.last, out_data.last);
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_store();
    test_value_extremes();
    test_fill_and_overflow();
    test_random_traffic(384);
    in_valid <= 1'b0;
    // drain outstanding results, then watch for strays
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #15_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sorted_list_insert_delete.f =====
design/slid_pkg.sv
design/slid_mem.sv
design/slid_oreg.sv
design/slid_ctrl.sv
design/sorted_list_insert_delete.sv
design/slid_chk.sv
bench/tb_top.sv
